// File: sv/fwna_pkg.sv
// ----------------------------------------------------------------------------
// fwna_pkg: shared types and constants
// Character codes, mode codes and widths for the number-to-ASCII formatter.
// ----------------------------------------------------------------------------
`default_nettype none

package fwna_pkg;

	localparam int MAX_DIGITS = 32;
	localparam int BCD_DIGITS = 10;
	localparam int BCD_W      = BCD_DIGITS * 4;
	localparam int NUM_W      = 32;
	localparam int HEX_DIGITS = NUM_W / 4;

	localparam logic [1:0] FUNC_UDEC = 2'd0;
	localparam logic [1:0] FUNC_SDEC = 2'd1;
	localparam logic [1:0] FUNC_HEX  = 2'd2;
	localparam logic [1:0] FUNC_BIN  = 2'd3;

	localparam logic [6:0] ASCII_ZERO  = 7'h30;
	localparam logic [6:0] ASCII_UPPER = 7'h41;
	localparam logic [6:0] ASCII_PLUS  = 7'h2B;
	localparam logic [6:0] ASCII_MINUS = 7'h2D;

	// Handshake between the sequencer and the BCD converter.
	typedef struct packed {
		logic              load;
		logic [NUM_W-1:0]  value;
	} conv_req_t;

	function automatic logic [6:0] digit_to_ascii(input logic [3:0] d);
		logic [6:0] code;
		if (d < 4'd10) begin
			code = ASCII_ZERO + {3'd0, d};
		end else begin
			code = ASCII_UPPER + {3'd0, d - 4'd10};
		end
		return code;
	endfunction

endpackage

`default_nettype wire

// File: sv/fwna_bcd_conv.sv
// ----------------------------------------------------------------------------
// fwna_bcd_conv: iterative binary to BCD converter
// Shift-and-add-3 over one input bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module fwna_bcd_conv
	import fwna_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  conv_req_t             req,
	output logic                  running,
	output logic [BCD_W-1:0]      bcd
);

	logic                 run_q;
	logic [4:0]           cnt_q;
	logic [NUM_W-1:0]     sh_q;
	logic [BCD_W-1:0]     bcd_q;
	logic [BCD_W-1:0]     adj;

	// Every BCD digit of five or more gets three added before the shift.
	always_comb begin
		for (int i = 0; i < BCD_DIGITS; i++) begin
			if (bcd_q[i*4 +: 4] >= 4'd5) begin
				adj[i*4 +: 4] = bcd_q[i*4 +: 4] + 4'd3;
			end else begin
				adj[i*4 +: 4] = bcd_q[i*4 +: 4];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			cnt_q <= '0;
		end else if (req.load) begin
			run_q <= 1'b1;
			cnt_q <= '0;
		end else if (run_q) begin
			cnt_q <= cnt_q + 5'd1;
			if (cnt_q == 5'd31) begin
				run_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.load) begin
			sh_q  <= req.value;
			bcd_q <= '0;
		end else if (run_q) begin
			sh_q  <= {sh_q[NUM_W-2:0], 1'b0};
			bcd_q <= {adj[BCD_W-2:0], sh_q[NUM_W-1]};
		end
	end

	assign running = run_q;
	assign bcd     = bcd_q;

endmodule

`default_nettype wire

// File: sv/fixed_width_number_to_ascii.sv
// ----------------------------------------------------------------------------
// fixed_width_number_to_ascii: fixed-width number formatter
// Emits one ASCII character per cycle once its digits are ready, most significant digit first.
// ----------------------------------------------------------------------------
// Decimal modes first run the value through the shared BCD shift-and-add-3 unit,
// then emit one character per cycle, with the sign first in signed mode.
// Hex and binary skip the converter.
// In hex and binary the first character follows start through ST_DIGIT and the output register.
// Results are strobed for one cycle each; the receiver cannot stall.
// Reset (arst_n low) returns the sequencer to idle and clears the strobe.
`default_nettype none

module fixed_width_number_to_ascii
	import fwna_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         start,
	output logic              busy,
	input  wire logic [1:0]   func,
	input  wire logic [31:0]  number,
	input  wire logic [5:0]   digit_count,
	input  wire logic [2:0]   line_number,
	input  wire logic [4:0]   start_column,
	output logic              strobe,
	output logic [2:0]        out_line,
	output logic [6:0]        out_column,
	output logic [6:0]        char_code,
	output logic              last_char
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_CONV  = 2'd1;
	localparam logic [1:0] ST_SIGN  = 2'd2;
	localparam logic [1:0] ST_DIGIT = 2'd3;

	logic [1:0]        state_q;
	logic [1:0]        func_q;
	logic [NUM_W-1:0]  mag_q;
	logic              neg_q;
	logic              zero_cnt_q;
	logic [4:0]        pos_q;
	logic [5:0]        offs_q;
	logic [2:0]        line_q;
	logic [4:0]        col_q;

	logic              strobe_q;
	logic [2:0]        out_line_q;
	logic [6:0]        out_column_q;
	logic [6:0]        char_code_q;
	logic              last_char_q;

	logic              accept;
	logic              is_dec;
	logic [5:0]        cnt_sat;
	logic              in_neg;
	logic [NUM_W-1:0]  in_mag;
	conv_req_t         conv_req;
	logic              conv_running;
	logic [BCD_W-1:0]  bcd;
	logic [3:0]        bcd_arr [BCD_DIGITS];
	logic [3:0]        hex_arr [HEX_DIGITS];
	logic [3:0]        digit;
	logic [6:0]        column;

	assign accept  = start && (state_q == ST_IDLE);
	assign busy    = (state_q != ST_IDLE);
	assign is_dec  = (func == FUNC_UDEC) || (func == FUNC_SDEC);
	assign cnt_sat = (digit_count > 6'(MAX_DIGITS)) ? 6'(MAX_DIGITS) : digit_count;
	assign in_neg  = (func == FUNC_SDEC) && number[NUM_W-1];
	assign in_mag  = in_neg ? (~number + 32'd1) : number;

	assign conv_req.load  = accept && is_dec;
	assign conv_req.value = in_mag;

	fwna_bcd_conv u_conv (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (conv_req),
		.running (conv_running),
		.bcd     (bcd)
	);

	always_comb begin
		for (int i = 0; i < BCD_DIGITS; i++) begin
			bcd_arr[i] = bcd[i*4 +: 4];
		end
		for (int i = 0; i < HEX_DIGITS; i++) begin
			hex_arr[i] = mag_q[i*4 +: 4];
		end
	end

	// Positions above the number's width read as zero.
	always_comb begin
		unique case (func_q)
			FUNC_HEX: begin
				digit = (pos_q < 5'(HEX_DIGITS)) ? hex_arr[pos_q[2:0]] : 4'd0;
			end
			FUNC_BIN: begin
				digit = {3'd0, mag_q[pos_q]};
			end
			default: begin
				digit = (pos_q < 5'(BCD_DIGITS)) ? bcd_arr[pos_q[3:0]] : 4'd0;
			end
		endcase
	end

	assign column = {2'd0, col_q} + {1'b0, offs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (is_dec) begin
							state_q <= ST_CONV;
						end else if (cnt_sat != 6'd0) begin
							state_q <= ST_DIGIT;
						end
					end
				end
				ST_CONV: begin
					if (!conv_running) begin
						if (func_q == FUNC_SDEC) begin
							state_q <= ST_SIGN;
						end else if (zero_cnt_q) begin
							state_q <= ST_IDLE;
						end else begin
							state_q <= ST_DIGIT;
						end
					end
				end
				ST_SIGN: begin
					strobe_q <= 1'b1;
					state_q  <= zero_cnt_q ? ST_IDLE : ST_DIGIT;
				end
				ST_DIGIT: begin
					strobe_q <= 1'b1;
					if (pos_q == 5'd0) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			func_q     <= func;
			mag_q      <= in_mag;
			neg_q      <= in_neg;
			zero_cnt_q <= (cnt_sat == 6'd0);
			pos_q      <= 5'(cnt_sat - 6'd1);
			offs_q     <= '0;
			line_q     <= line_number;
			col_q      <= start_column;
		end else if (state_q == ST_SIGN) begin
			offs_q <= offs_q + 6'd1;
		end else if (state_q == ST_DIGIT) begin
			offs_q <= offs_q + 6'd1;
			pos_q  <= pos_q - 5'd1;
		end
	end

	always_ff @(posedge clk) begin
		out_line_q   <= line_q;
		out_column_q <= column;
		if (state_q == ST_SIGN) begin
			char_code_q <= neg_q ? ASCII_MINUS : ASCII_PLUS;
			last_char_q <= zero_cnt_q;
		end else begin
			char_code_q <= digit_to_ascii(digit);
			last_char_q <= (pos_q == 5'd0);
		end
	end

	assign strobe     = strobe_q;
	assign out_line   = out_line_q;
	assign out_column = out_column_q;
	assign char_code  = char_code_q;
	assign last_char  = last_char_q;

endmodule

`default_nettype wire

// File: dv/fwna_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fwna_checker: result checker for the number-to-ASCII formatter
// Watches the request and character channels, predicts the characters of
// every accepted request and compares each strobed character in order.
// ----------------------------------------------------------------------------

module fwna_checker
	import fwna_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         start,
	input  wire logic         busy,
	input  wire logic [1:0]   func,
	input  wire logic [31:0]  number,
	input  wire logic [5:0]   digit_count,
	input  wire logic [2:0]   line_number,
	input  wire logic [4:0]   start_column,
	input  wire logic         strobe,
	input  wire logic [2:0]   out_line,
	input  wire logic [6:0]   out_column,
	input  wire logic [6:0]   char_code,
	input  wire logic         last_char,
	output int                fail_count,
	output int                pending,
	output int                chars_checked
);

	typedef struct packed {
		logic [2:0] line;
		logic [6:0] column;
		logic [6:0] code;
		logic       last;
	} ascii_char_t;

	ascii_char_t expected_chars[$];
	int          errors;
	int          compared;

	initial begin
		errors        = 0;
		compared      = 0;
		fail_count    = 0;
		pending       = 0;
		chars_checked = 0;
	end

	// Queues every character one request should produce, sign first.
	function automatic void predict_chars(input logic [1:0] mode, input logic [31:0] value,
			input logic [5:0] count_in, input logic [2:0] line, input logic [4:0] col);
		int unsigned count;
		int unsigned radix;
		int unsigned pos;
		logic [31:0] mag;
		logic [3:0]  digs[MAX_DIGITS];
		logic [3:0]  d;
		ascii_char_t c;
		count = (count_in > MAX_DIGITS) ? MAX_DIGITS : count_in;
		mag   = value;
		pos   = 0;
		if (mode == FUNC_SDEC) begin
			c.line   = line;
			c.column = {2'b00, col};
			c.code   = value[31] ? ASCII_MINUS : ASCII_PLUS;
			c.last   = (count == 0);
			if (value[31]) begin
				mag = ~value + 32'd1;
			end
			expected_chars.push_back(c);
			pos = 1;
		end
		case (mode)
			FUNC_HEX: begin
				radix = 16;
			end
			FUNC_BIN: begin
				radix = 2;
			end
			default: begin
				radix = 10;
			end
		endcase
		// Positions beyond the value's width come out as zero digits.
		for (int p = 0; p < MAX_DIGITS; p++) begin
			digs[p] = 4'(mag % radix);
			mag     = mag / radix;
		end
		for (int unsigned i = 0; i < count; i++) begin
			d        = digs[count - 1 - i];
			c.line   = line;
			c.column = 7'({2'b00, col} + pos);
			c.code   = (d < 4'd10) ? ASCII_ZERO + {3'b000, d}
			                       : ASCII_UPPER + {3'b000, d - 4'd10};
			c.last   = (i + 1 == count);
			expected_chars.push_back(c);
			pos++;
		end
	endfunction

	always @(posedge clk) begin
		ascii_char_t want;
		ascii_char_t got;
		logic        bad;
		if (arst_n) begin
			if (strobe === 1'b1) begin
				got = '{line: out_line, column: out_column, code: char_code, last: last_char};
				if (expected_chars.size() == 0) begin
					$error("character with no request pending: line %0d column %0d code 0x%02h",
						out_line, out_column, char_code);
					errors++;
				end else begin
					want = expected_chars.pop_front();
					bad  = 1'b0;
					if (got.line !== want.line) begin
						$error("out_line: expected %0d, actual %0d", want.line, got.line);
						bad = 1'b1;
					end
					if (got.column !== want.column) begin
						$error("out_column: expected %0d, actual %0d", want.column, got.column);
						bad = 1'b1;
					end
					if (got.code !== want.code) begin
						$error("char_code: expected 0x%02h, actual 0x%02h", want.code, got.code);
						bad = 1'b1;
					end
					if (got.last !== want.last) begin
						$error("last_char: expected %0d, actual %0d", want.last, got.last);
						bad = 1'b1;
					end
					if (bad) begin
						errors++;
					end
					compared++;
				end
			end
			if (start === 1'b1 && busy === 1'b0) begin
				predict_chars(func, number, digit_count, line_number, start_column);
			end
		end
		fail_count    <= errors;
		pending       <= expected_chars.size();
		chars_checked <= compared;
	end

	// Anything still queued once the run is over was never produced.
	function automatic int leftover_count();
		if (expected_chars.size() != 0) begin
			$error("%0d expected characters never arrived", expected_chars.size());
		end
		return expected_chars.size();
	endfunction

endmodule

// File: dv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: top level for the number-to-ASCII formatter
// Sends directed and random requests with random gaps and reports the verdict
// from the checker's failure count and its check for characters left queued.
// ----------------------------------------------------------------------------

module testbench;
	import fwna_pkg::*;

	localparam int CYCLE_LIMIT  = 200000;
	localparam int RANDOM_ITEMS = 200;
	localparam int TAIL_CYCLES  = 80;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [1:0]  func;
	logic [31:0] number;
	logic [5:0]  digit_count;
	logic [2:0]  line_number;
	logic [4:0]  start_column;
	logic        strobe;
	logic [2:0]  out_line;
	logic [6:0]  out_column;
	logic [6:0]  char_code;
	logic        last_char;

	int fail_count;
	int pending;
	int chars_checked;
	int requests_per_mode[4];
	int quiet_left;
	int cycles;

	fixed_width_number_to_ascii u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.func         (func),
		.number       (number),
		.digit_count  (digit_count),
		.line_number  (line_number),
		.start_column (start_column),
		.strobe       (strobe),
		.out_line     (out_line),
		.out_column   (out_column),
		.char_code    (char_code),
		.last_char    (last_char)
	);

	fwna_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.func          (func),
		.number        (number),
		.digit_count   (digit_count),
		.line_number   (line_number),
		.start_column  (start_column),
		.strobe        (strobe),
		.out_line      (out_line),
		.out_column    (out_column),
		.char_code     (char_code),
		.last_char     (last_char),
		.fail_count    (fail_count),
		.pending       (pending),
		.chars_checked (chars_checked)
	);

	initial begin
		clk = 1'b0;
	end

	always begin
		#10 clk = ~clk;
	end

	initial begin
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("timeout after %0d cycles", cycles);
		$display("testbench failed");
		$finish;
	end

	// Mostly back-to-back or short gaps, a few long ones, and now and then a
	// quiet stretch with no gaps at all.
	function automatic int pick_gap();
		int r;
		if (quiet_left > 0) begin
			quiet_left--;
			return 0;
		end
		if ($urandom_range(0, 15) == 0) begin
			quiet_left = $urandom_range(5, 20);
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 45) begin
			return 0;
		end else if (r < 85) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(10, 60);
	endfunction

	// Presents one request, holds it until accepted, then idles for a gap.
	task automatic send_request(input logic [1:0] mode, input logic [31:0] value,
			input logic [5:0] count, input logic [2:0] line, input logic [4:0] col);
		int gap;
		start        = 1'b1;
		func         = mode;
		number       = value;
		digit_count  = count;
		line_number  = line;
		start_column = col;
		do begin
			@(posedge clk);
		end while (busy !== 1'b0);
		requests_per_mode[mode]++;
		@(negedge clk);
		gap = pick_gap();
		if (gap > 0) begin
			start        = 1'b0;
			func         = 2'($urandom);
			number       = $urandom;
			digit_count  = 6'($urandom);
			line_number  = 3'($urandom);
			start_column = 5'($urandom);
			repeat (gap) @(negedge clk);
		end
	endtask

	initial begin
		logic [1:0]  mode;
		logic [31:0] value;
		logic [31:0] pow10;
		logic [5:0]  count;
		int          r;
		arst_n       = 1'b0;
		start        = 1'b0;
		func         = FUNC_UDEC;
		number       = '0;
		digit_count  = '0;
		line_number  = '0;
		start_column = '0;
		quiet_left   = 0;
		foreach (requests_per_mode[m]) requests_per_mode[m] = 0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: field extremes, every mode and the corner cases.
		send_request(FUNC_UDEC, 32'd0,          6'd1,  3'd1, 5'd1);
		send_request(FUNC_UDEC, 32'hFFFF_FFFF,  6'd10, 3'd2, 5'd3);
		send_request(FUNC_UDEC, 32'hFFFF_FFFF,  6'd12, 3'd3, 5'd2);
		send_request(FUNC_UDEC, 32'd1234567890, 6'd4,  3'd4, 5'd5);
		send_request(FUNC_UDEC, 32'd5,          6'd0,  3'd1, 5'd1);
		send_request(FUNC_SDEC, 32'h8000_0000,  6'd10, 3'd1, 5'd1);
		send_request(FUNC_SDEC, 32'h7FFF_FFFF,  6'd10, 3'd2, 5'd4);
		send_request(FUNC_SDEC, 32'hFFFF_FFFF,  6'd3,  3'd3, 5'd9);
		send_request(FUNC_SDEC, 32'd0,          6'd0,  3'd4, 5'd16);
		send_request(FUNC_SDEC, 32'd12345,      6'd33, 3'd7, 5'd31);
		send_request(FUNC_SDEC, 32'h8000_0000,  6'd0,  3'd0, 5'd0);
		send_request(FUNC_HEX,  32'hFEDC_BA98,  6'd8,  3'd1, 5'd1);
		send_request(FUNC_HEX,  32'h0123_4567,  6'd8,  3'd2, 5'd7);
		send_request(FUNC_HEX,  32'hFFFF_FFFF,  6'd32, 3'd3, 5'd1);
		send_request(FUNC_HEX,  32'd0,          6'd0,  3'd4, 5'd2);
		send_request(FUNC_BIN,  32'hAAAA_AAAA,  6'd32, 3'd1, 5'd1);
		send_request(FUNC_BIN,  32'h5555_5555,  6'd32, 3'd0, 5'd0);
		send_request(FUNC_BIN,  32'd5,          6'd63, 3'd2, 5'd12);
		send_request(FUNC_BIN,  32'd1,          6'd1,  3'd4, 5'd16);
		send_request(FUNC_UDEC, 32'hFFFF_FFFF,  6'd63, 3'd7, 5'd31);

		// Random requests, mostly short digit counts.
		repeat (RANDOM_ITEMS) begin
			mode = 2'($urandom_range(0, 3));
			r = $urandom_range(0, 3);
			case (r)
				0: begin
					value = $urandom;
				end
				1: begin
					value = $urandom_range(0, 99);
				end
				2: begin
					pow10 = 32'd1;
					repeat ($urandom_range(0, 9)) pow10 = pow10 * 32'd10;
					value = pow10 - $urandom_range(0, 1);
					if ($urandom_range(0, 1) == 1) begin
						value = ~value + 32'd1;
					end
				end
				default: begin
					value = $urandom >> $urandom_range(0, 31);
				end
			endcase
			r = $urandom_range(0, 99);
			if (r < 70) begin
				count = 6'($urandom_range(1, 12));
			end else if (r < 90) begin
				count = 6'($urandom_range(13, 32));
			end else if (r < 95) begin
				count = 6'd0;
			end else begin
				count = 6'($urandom_range(33, 63));
			end
			send_request(mode, value, count, 3'($urandom_range(0, 7)),
				5'($urandom_range(0, 31)));
		end

		start = 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (TAIL_CYCLES) @(negedge clk);

		$display("Sent %0d requests: %0d unsigned, %0d signed, %0d hex, %0d binary.",
			requests_per_mode[FUNC_UDEC] + requests_per_mode[FUNC_SDEC] +
			requests_per_mode[FUNC_HEX] + requests_per_mode[FUNC_BIN],
			requests_per_mode[FUNC_UDEC], requests_per_mode[FUNC_SDEC],
			requests_per_mode[FUNC_HEX], requests_per_mode[FUNC_BIN]);
		$display("Compared %0d characters against prediction.", chars_checked);
		if (fail_count == 0 && u_checker.leftover_count() == 0) begin
			$display("testbench passed");
		end else begin
			$display("testbench failed");
		end
		$finish;
	end

endmodule
